// File: hw/rtl/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants of the decimal ascii formatter
// Holds the queue entry between the converter and the emitter, the state
// enums and the character codes.
// ----------------------------------------------------------------------------
package bda_pkg;

  // number of decimal digits of a 32-bit magnitude
  localparam int unsigned DigitCount  = 10;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned PosWidth    = 4;
  // double dabble: bits shifted in per cycle and cycles per word
  localparam int unsigned BitsPerStep = 4;
  localparam int unsigned ConvSteps   = ValueWidth / BitsPerStep;
  localparam int unsigned StepCntW    = $clog2(ConvSteps);

  // ascii codes
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharPoint = 8'h2e;

  // digit positions
  localparam logic [PosWidth-1:0] PosOnes = 4'd1;
  localparam logic [PosWidth-1:0] PosTop  = 4'd10;

  typedef logic [DigitCount-1:0][3:0] bcd_t;

  // classified number waiting for the emitter
  typedef struct packed {
    logic                neg;    // '-' goes first
    bcd_t                bcd;    // magnitude in decimal digits
    logic [PosWidth-1:0] start;  // first digit position to print
    logic [PosWidth-1:0] point;  // point position, 0 = none
  } entry_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CONV,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SIGN,
    BK_LEAD_PT,
    BK_POINT,
    BK_DIGIT
  } bk_state_e;

endpackage

// File: hw/rtl/bda_front.sv
// ----------------------------------------------------------------------------
// bda_front: input stage and binary to bcd converter
// Takes one number, works out sign and magnitude, converts the magnitude to
// ten bcd digits four bits a cycle and finds the first digit to print.
// ----------------------------------------------------------------------------
module bda_front import bda_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  operation_i,
  input  logic [ValueWidth-1:0] value_i,
  input  logic                  show_leading_zeros_i,
  input  logic [PosWidth-1:0]   point_position_i,
  output logic                  push_o,
  output entry_t                entry_o,
  input  logic                  full_i
);

  fr_state_e             st_q, st_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic [ValueWidth-1:0] mag_q, mag_d;
  bcd_t                  bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic                  lz_q, lz_d;
  logic [PosWidth-1:0]   point_q, point_d;
  logic                  accept;
  logic                  neg_in;
  logic [PosWidth-1:0]   start;

  // one double dabble pass: adjust every digit, then shift one bit in
  function automatic bcd_t dabble(bcd_t b, logic bit_in);
    bcd_t r;
    r = b;
    for (int i = 0; i < DigitCount; i++) begin
      if (r[i] >= 4'd5) r[i] = r[i] + 4'd3;
    end
    r = {r[DigitCount-1][2:0], r[DigitCount-2:0], bit_in};
    return r;
  endfunction

  // handshake
  assign in_ready_o = (st_q == FR_IDLE) || (st_q == FR_PUSH && !full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign neg_in     = operation_i && value_i[ValueWidth-1];

  // first printed digit position
  always_comb begin
    start = PosOnes;
    for (int k = 1; k <= DigitCount; k++) begin
      if (bcd_q[k-1] != 4'd0) start = PosWidth'(k);
    end
    if (lz_q) start = PosTop;
  end

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      FR_IDLE: if (accept) st_d = FR_CONV;
      FR_CONV: if (cnt_q == StepCntW'(ConvSteps - 1)) st_d = FR_PUSH;
      FR_PUSH: begin
        if (accept) st_d = FR_CONV;
        else if (!full_i) st_d = FR_IDLE;
      end
      default: st_d = FR_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    lz_d    = lz_q;
    point_d = point_q;
    if (accept) begin
      cnt_d   = '0;
      neg_d   = neg_in;
      mag_d   = neg_in ? (ValueWidth'(0) - value_i) : value_i;
      bcd_d   = '0;
      lz_d    = show_leading_zeros_i;
      point_d = point_position_i;
    end else if (st_q == FR_CONV) begin
      for (int j = 0; j < BitsPerStep; j++) begin
        bcd_d = dabble(bcd_d, mag_d[ValueWidth-1]);
        mag_d = {mag_d[ValueWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q + StepCntW'(1);
    end
  end

  // outputs
  assign push_o        = (st_q == FR_PUSH) && !full_i;
  assign entry_o.neg   = neg_q;
  assign entry_o.bcd   = bcd_q;
  assign entry_o.start = start;
  assign entry_o.point = point_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= FR_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
    lz_q    <= lz_d;
    point_q <= point_d;
  end

endmodule

// File: hw/rtl/bda_queue.sv
// ----------------------------------------------------------------------------
// bda_queue: small queue of classified numbers
// Register based first-in first-out store between converter and emitter.
// Depth must be a power of two.
// ----------------------------------------------------------------------------
module bda_queue import bda_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t           mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [AddrW:0]   cnt_q;

  assign full_o  = (cnt_q == (AddrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AddrW'(1);
      if (pop_i)  rd_q <= rd_q + AddrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (AddrW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (AddrW+1)'(1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

endmodule

// File: hw/rtl/bda_back.sv
// ----------------------------------------------------------------------------
// bda_back: character emitter
// Walks one classified number and gives one ascii character a beat:
// sign, a point ahead of suppressed zeros, then digits with the point.
// ----------------------------------------------------------------------------
module bda_back import bda_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  entry_t     head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] character_o,
  output logic       last_o
);

  bk_state_e           st_q, st_d, cur_st, nxt_st;
  logic [PosWidth-1:0] pos_q, pos_d, cur_pos, nxt_pos, pos_dn;
  entry_t              held_q, cur;
  logic                step, emit;
  logic                valid_q, valid_d;
  logic [7:0]          char_q, char_d;
  logic                last_q, last_d;

  function automatic logic [3:0] digit_at(bcd_t b, logic [PosWidth-1:0] p);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= DigitCount; k++) begin
      if (p == PosWidth'(k)) d = b[k-1];
    end
    return d;
  endfunction

  // what follows the sign
  function automatic bk_state_e after_sign(entry_t e);
    bk_state_e s;
    if (e.point > e.start && e.point <= PosTop) s = BK_LEAD_PT;
    else if (e.point == e.start)                s = BK_POINT;
    else                                        s = BK_DIGIT;
    return s;
  endfunction

  // current number: the queue head when idle, else the held one
  always_comb begin
    if (st_q == BK_IDLE) begin
      cur     = head_i;
      cur_pos = head_i.start;
      if (empty_i)          cur_st = BK_IDLE;
      else if (head_i.neg)  cur_st = BK_SIGN;
      else                  cur_st = after_sign(head_i);
    end else begin
      cur     = held_q;
      cur_pos = pos_q;
      cur_st  = st_q;
    end
  end

  assign step   = !valid_q || out_ready_i;
  assign emit   = step && (cur_st != BK_IDLE);
  assign pop_o  = emit && (st_q == BK_IDLE);
  assign pos_dn = cur_pos - PosWidth'(1);

  // next state
  always_comb begin
    nxt_st  = cur_st;
    nxt_pos = cur_pos;
    case (cur_st)
      BK_SIGN: begin
        nxt_st  = after_sign(cur);
        nxt_pos = cur.start;
      end
      BK_LEAD_PT: nxt_st = BK_DIGIT;
      BK_POINT:   nxt_st = BK_DIGIT;
      BK_DIGIT: begin
        if (cur_pos == PosOnes) begin
          nxt_st = BK_IDLE;
        end else begin
          nxt_pos = pos_dn;
          nxt_st  = (cur.point == pos_dn) ? BK_POINT : BK_DIGIT;
        end
      end
      default: nxt_st = BK_IDLE;
    endcase
    st_d  = st_q;
    pos_d = pos_q;
    if (emit) begin
      st_d  = nxt_st;
      pos_d = nxt_pos;
    end
  end

  // character of this beat
  always_comb begin
    char_d = char_q;
    last_d = last_q;
    if (emit) begin
      last_d = 1'b0;
      case (cur_st)
        BK_SIGN:    char_d = CharMinus;
        BK_LEAD_PT: char_d = CharPoint;
        BK_POINT:   char_d = CharPoint;
        BK_DIGIT: begin
          char_d = CharZero + {4'b0, digit_at(cur.bcd, cur_pos)};
          last_d = (cur_pos == PosOnes);
        end
        default:    char_d = char_q;
      endcase
    end
  end

  assign valid_d     = emit || (valid_q && !out_ready_i);
  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    char_q <= char_d;
    last_q <= last_d;
    if (pop_o) held_q <= head_i;
  end

endmodule

// File: hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 32-bit number to decimal ascii text
// Formats one number, signed or unsigned, as a run of ascii characters with
// optional leading zeros and a decimal point.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                 tuser / tlast
//  s_axis   in   value[31:0], point_position[35:32]    operation, show_lz
//  m_axis   out  character[7:0]                        last of the number
//
//  the converter works four bits a cycle and takes a new number only when idle
//  or while it hands the last converted one over to the queue.
//  the emitter gives one character a cycle while the output is not stalled,
//  1 to 12 per number; the sustained rate is set by the slower of the two.
//  reset clears all control state; there is no clearing pass.
//  output stalls fill the queue, then hold the converter and the input.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import bda_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value[31:0], point_position[35:32]
  input  logic [1:0]  s_axis_tuser,   // operation[0], show_leading_zeros[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // character[7:0]
  output logic        m_axis_tlast
);

  logic   push, full, pop, empty;
  entry_t entry, head;

  // converter
  bda_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (s_axis_tvalid),
    .in_ready_o           (s_axis_tready),
    .operation_i          (s_axis_tuser[0]),
    .value_i              (s_axis_tdata[31:0]),
    .show_leading_zeros_i (s_axis_tuser[1]),
    .point_position_i     (s_axis_tdata[35:32]),
    .push_o               (push),
    .entry_o              (entry),
    .full_i               (full)
  );

  // queue between the two halves
  bda_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  // emitter
  bda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .character_o (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

// File: hw/rtl/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker: port checks of the formatter
// Watches the output stream for legal characters and run structure.
// ----------------------------------------------------------------------------
module bda_checker import bda_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  logic is_digit;
  assign is_digit = (m_axis_tdata >= CharZero) && (m_axis_tdata <= CharZero + 8'd9);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // only digits, sign and point appear
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (is_digit || m_axis_tdata == CharMinus || m_axis_tdata == CharPoint))
    else $error("illegal character");

  // every number ends in its ones digit
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> is_digit)
    else $error("last beat is not a digit");

  // a sign is never the whole number
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata == CharMinus |-> !m_axis_tlast)
    else $error("sign marked last");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb: self-checking bench of the decimal ascii formatter
// Sends numbers in both signed and unsigned form, with and without leading
// zeros and with every point position, on the input stream. Each number is
// turned into its expected text as it is taken, and every character beat on
// the output stream is compared with that text in order. Both sides idle at
// random, the output is held off long enough to back up the input, and the
// input is paused once until the output has drained.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;
  import bda_pkg::*;

  localparam int unsigned LongHold   = 400;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned CycleLimit = 600000;

  typedef enum logic {
    FMT_UNSIGNED = 1'b0,
    FMT_SIGNED   = 1'b1
  } fmt_e;

  // one number as offered on the input stream
  typedef struct packed {
    fmt_e                  fmt;
    logic [ValueWidth-1:0] value;
    logic                  lead_zeros;
    logic [PosWidth-1:0]   point;
  } number_t;

  // one character as expected on the output stream
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_t;

  // expected text of every taken number, in output order
  class ascii_text_board;
    char_t       pending_chars[$];
    int unsigned mismatches;
    int unsigned chars_seen;

    task report(string msg);
      $display("MISMATCH at char %0d: %s", chars_seen, msg);
      mismatches++;
    endtask

    // work out the text of one number and queue it
    task queue_decimal_text(number_t n);
      logic [ValueWidth-1:0] mag;
      logic [ValueWidth-1:0] place;
      logic [3:0]            digit;
      logic                  printing;
      int                    pos;
      int                    idx;
      mag      = n.value;
      place    = 32'd1000000000;
      printing = n.lead_zeros;
      if (n.fmt == FMT_SIGNED && mag[ValueWidth-1]) begin
        pending_chars.push_back('{code: CharMinus, last: 1'b0});
        mag = 32'd0 - mag;
      end
      // billions down to ones, point goes ahead of its digit
      for (pos = 10; pos >= 1; pos--) begin
        digit = 4'(mag / place);
        mag   = mag % place;
        if (n.point == pos) begin
          pending_chars.push_back('{code: CharPoint, last: 1'b0});
        end
        if (printing || digit != 4'd0 || pos == 1) begin
          pending_chars.push_back('{code: CharZero + 8'(digit), last: 1'b0});
          printing = 1'b1;
        end
        place = place / 10;
      end
      idx = pending_chars.size() - 1;
      pending_chars[idx].last = 1'b1;
    endtask

    task check_char(logic [7:0] code, logic last);
      char_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last %0b", code, last));
        chars_seen++;
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        report($sformatf("char 0x%02h, expected 0x%02h", code, want.code));
      end
      if (last !== want.last) begin
        report($sformatf("last %0b, expected %0b", last, want.last));
      end
      chars_seen++;
    endtask

    function int unsigned outstanding();
      return pending_chars.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // value[31:0], point_position[35:32]
  logic [1:0]  s_axis_tuser;   // operation[0], show_leading_zeros[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // character[7:0]
  logic        m_axis_tlast;

  ascii_text_board board = new();
  bit              no_idling;
  bit              hold_request;
  int unsigned     cycle_count;

  binary_to_decimal_ascii u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // output beat checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  // output side: random stalls per beat, one long hold on request
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end
      stall = no_idling ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic number_t make_number(fmt_e fmt, logic [31:0] value, logic lead_zeros,
                                          logic [3:0] point);
    number_t n;
    n.fmt        = fmt;
    n.value      = value;
    n.lead_zeros = lead_zeros;
    n.point      = point;
    return n;
  endfunction

  // random number, weighted toward short values and the ends of the range
  function automatic number_t random_number();
    number_t     n;
    int unsigned place;
    n.fmt        = fmt_e'($urandom_range(0, 1));
    n.lead_zeros = 1'($urandom_range(0, 1));
    n.point      = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(11, 15))
                                               : 4'($urandom_range(0, 10));
    case ($urandom_range(0, 7))
      0: n.value = $urandom_range(0, 9);
      1: n.value = $urandom_range(0, 99999);
      2: n.value = 32'h8000_0000 ^ 32'($urandom_range(0, 15));
      3: n.value = 32'hffff_ffff - 32'($urandom_range(0, 15));
      4: begin
        place = 1;
        repeat ($urandom_range(0, 9)) place = place * 10;
        n.value = place + $urandom_range(0, 2) - 1;
      end
      default: n.value = $urandom;
    endcase
    return n;
  endfunction

  function automatic int unsigned sender_gap();
    return no_idling ? 0 : $urandom_range(0, 19);
  endfunction

  // offer one number and wait for its beat; entered and left at a falling edge
  task automatic send_number(number_t n, int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'd0, n.point, n.value};
    s_axis_tuser  = {n.lead_zeros, n.fmt};
    do @(posedge clk_i); while (!s_axis_tready);
    board.queue_decimal_text(n);
    @(negedge clk_i);
  endtask

  initial begin
    number_t directed[$];
    int      i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    no_idling     = 1'b0;
    hold_request  = 1'b0;
    cycle_count   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero, both extremes and the signed corners
    directed.push_back(make_number(FMT_UNSIGNED, 32'd0, 1'b0, 4'd0));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd0, 1'b1, 4'd0));
    directed.push_back(make_number(FMT_UNSIGNED, 32'hffff_ffff, 1'b0, 4'd0));
    directed.push_back(make_number(FMT_UNSIGNED, 32'hffff_ffff, 1'b1, 4'd10));
    directed.push_back(make_number(FMT_SIGNED, 32'h8000_0000, 1'b0, 4'd0));
    directed.push_back(make_number(FMT_SIGNED, 32'h8000_0000, 1'b1, 4'd10));
    directed.push_back(make_number(FMT_SIGNED, 32'hffff_ffff, 1'b0, 4'd0));
    directed.push_back(make_number(FMT_SIGNED, 32'h7fff_ffff, 1'b0, 4'd1));
    directed.push_back(make_number(FMT_SIGNED, 32'd0, 1'b1, 4'd5));
    directed.push_back(make_number(FMT_SIGNED, 32'd42, 1'b0, 4'd2));
    // point ahead of suppressed zeros
    directed.push_back(make_number(FMT_UNSIGNED, 32'd5, 1'b0, 4'd3));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd0, 1'b0, 4'd1));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd0, 1'b0, 4'd10));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd123, 1'b0, 4'd1));
    directed.push_back(make_number(FMT_SIGNED, 32'hffff_fff6, 1'b0, 4'd4));
    // point positions that match no digit
    directed.push_back(make_number(FMT_UNSIGNED, 32'd987654, 1'b0, 4'd11));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd987654, 1'b1, 4'd15));
    directed.push_back(make_number(FMT_SIGNED, 32'hdead_beef, 1'b0, 4'd13));
    // digit count changes
    directed.push_back(make_number(FMT_UNSIGNED, 32'd1000000000, 1'b0, 4'd0));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd999999999, 1'b0, 4'd9));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd10, 1'b0, 4'd0));
    directed.push_back(make_number(FMT_UNSIGNED, 32'd9, 1'b1, 4'd8));
    for (i = 0; i < directed.size(); i++) begin
      send_number(directed[i], sender_gap());
    end

    // random with idling on both sides
    repeat (150) send_number(random_number(), sender_gap());

    // long output hold while the input keeps offering
    hold_request = 1'b1;
    repeat (16) send_number(random_number(), 0);

    // input pause until the output has drained
    s_axis_tvalid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);

    // back to back, no idling on either side
    no_idling = 1'b1;
    repeat (120) send_number(random_number(), 0);
    no_idling = 1'b0;

    repeat (185) send_number(random_number(), sender_gap());
    s_axis_tvalid = 1'b0;

    // drain, then watch for stray beats
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
